// ===== sv/cvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_pkg: shared types and constants for the cost volume merge block
// Volume geometry, field widths, mode and register codes, and the payload
// and memory port structures used between the modules.
// ----------------------------------------------------------------------------
package cvm_pkg;

   // Volume geometry.
   localparam int DIM_X  = 128;
   localparam int DIM_Y  = 128;
   localparam int DIM_Z  = 64;
   localparam int VOXELS = DIM_X * DIM_Y * DIM_Z;
   localparam int ADDR_W = $clog2(VOXELS);

   // Field widths.
   localparam int POS_W   = 7;
   localparam int LZ_W    = 6;
   localparam int COST_W  = 8;
   localparam int SUM_W   = 2 * COST_W;
   localparam int ZSUM_W  = LZ_W + 1;
   localparam int SLICE_W = 7;
   localparam int MODE_W  = 2;

   localparam logic [COST_W-1:0] COST_MAX = 8'd255;

   // Merge modes.
   localparam logic [MODE_W-1:0] MODE_COPY = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MIN  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BEST2 = 2'd2;
   localparam logic [MODE_W-1:0] MODE_AVG  = 2'd3;

   // Control register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVG_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_BASE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLICE_COUNT = 2'd3;

   // Input transaction payload.
   typedef struct packed {
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [LZ_W-1:0]   local_z;
      logic [COST_W-1:0] cost;
   } req_data_type;

   // Result transaction payload.
   typedef struct packed {
      logic [COST_W-1:0] best_cost;
      logic [COST_W-1:0] second_cost;
      logic              rejected;
   } rsp_data_type;

   // Store write port.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [COST_W-1:0] best;
      logic [COST_W-1:0] second;
   } store_wr_type;

   // Store read port.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } store_rd_type;

   // Divider request.
   typedef struct packed {
      logic              start;
      logic [SUM_W-1:0]  dividend;
      logic [COST_W-1:0] divisor;
   } div_req_type;

endpackage

// ===== sv/cvm_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_store: best and second-best cost memories
// Two synchronous memories sharing one write port and one read port, with
// a registered read.
// ----------------------------------------------------------------------------
module cvm_store
   import cvm_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  store_rd_type      rd,
   output logic [COST_W-1:0] rd_best,
   output logic [COST_W-1:0] rd_second
);

   logic [COST_W-1:0] best_mem   [VOXELS];
   logic [COST_W-1:0] second_mem [VOXELS];
   logic [COST_W-1:0] rd_best_ff;
   logic [COST_W-1:0] rd_second_ff;

   // Write port: both stores are written together.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         best_mem[wr.addr]   <= wr.best;
         second_mem[wr.addr] <= wr.second;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_best_ff   <= best_mem[rd.addr];
         rd_second_ff <= second_mem[rd.addr];
      end
   end

   assign rd_best   = rd_best_ff;
   assign rd_second = rd_second_ff;

endmodule

// ===== sv/cvm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvm_div: iterative divider for the running average
// Restoring division, one quotient bit per cycle. The dividend never
// exceeds 255 times the divisor, so the quotient fits in a cost.
// ----------------------------------------------------------------------------
module cvm_div
   import cvm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       req,
   output logic              done,
   output logic [COST_W-1:0] quotient
);

   localparam int CNT_W = $clog2(COST_W);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [CNT_W-1:0]  cnt_ff,   cnt_in;
   logic [SUM_W-1:0]  rem_ff,   rem_in;
   logic [SUM_W-1:0]  dsh_ff,   dsh_in;
   logic [COST_W-1:0] quot_ff,  quot_in;

   // One trial subtraction per cycle, divisor shifted down each step.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(COST_W - 1);
         rem_in  = req.dividend;
         dsh_in  = SUM_W'({req.divisor, {(COST_W-1){1'b0}}});
         quot_in = '0;
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in  = rem_ff - dsh_ff;
            quot_in = {quot_ff[COST_W-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[COST_W-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== sv/cost_volume_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cost_volume_merge: stereo cost volume merge unit
// Merges incoming voxel costs into a best store and a second-best store.
// ----------------------------------------------------------------------------
// Usage:
//  - The req channel carries one voxel per transaction (position, local
//    slice, cost). The rsp channel returns one transaction per request with
//    the voxel's best and second-best costs after the merge, or a rejected
//    flag when the local slice lies outside the slice window, or the slice
//    or position lies outside the volume.
//  - The csr channel writes the merge mode, average count, base slice and
//    slice count. It is always ready. The user must see that it is written
//    only while the block is idle; the block itself does not enforce this.
//  - Items are handled one at a time through a read, merge and write-back
//    of the two memories; average mode adds the iterative divider before
//    the write-back, and a rejected item skips the read and merge. The next
//    item can be accepted in the same cycle that rsp_valid rises.
//  - After reset both memories are swept to 255, one voxel per cycle over
//    the whole volume; req_ready stays low during the sweep.
//  - The result sits in an output register. When rsp_ready is low, the
//    next item is still accepted and processed, and its write-back waits
//    until the pending result has been taken.
// ----------------------------------------------------------------------------
module cost_volume_merge
   import cvm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_data_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_data_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_MERGE = 3'd3;
   localparam logic [2:0] ST_DIVGO = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_WRITE = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   req_data_type       item_ff, item_in;
   logic               rej_ff, rej_in;
   logic [COST_W-1:0]  new_best_ff, new_best_in;
   logic [COST_W-1:0]  new_second_ff, new_second_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic [MODE_W-1:0]  merge_mode_ff;
   logic [COST_W-1:0]  avg_count_ff;
   logic [LZ_W-1:0]    z_base_ff;
   logic [SLICE_W-1:0] slice_count_ff;

   store_wr_type       wr;
   store_rd_type       rd;
   div_req_type        div_req;
   logic               div_done;
   logic [COST_W-1:0]  div_quot;
   logic [COST_W-1:0]  rd_best;
   logic [COST_W-1:0]  rd_second;

   logic [ZSUM_W-1:0]  z_sum;
   logic               item_rej;
   logic [ADDR_W-1:0]  item_addr;
   logic [COST_W-1:0]  avg_n;
   logic [COST_W-1:0]  avg_nm1;
   logic               rsp_free;

   // Control registers; writes always complete.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_mode_ff  <= MODE_MIN;
         avg_count_ff   <= COST_W'(1);
         z_base_ff      <= '0;
         slice_count_ff <= SLICE_W'(64);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MERGE_MODE:  merge_mode_ff  <= csr_data[MODE_W-1:0];
            CSR_AVG_COUNT:   avg_count_ff   <= csr_data[COST_W-1:0];
            CSR_Z_BASE:      z_base_ff      <= csr_data[LZ_W-1:0];
            CSR_SLICE_COUNT: slice_count_ff <= csr_data[SLICE_W-1:0];
            default: ;
         endcase
      end
   end

   // Range check and voxel address of the captured item.
   assign z_sum    = ZSUM_W'(z_base_ff) + ZSUM_W'(item_ff.local_z);
   assign item_rej = (SLICE_W'(item_ff.local_z) >= slice_count_ff)
                  || (32'(z_sum) >= DIM_Z)
                  || (32'(item_ff.pos_x) >= DIM_X)
                  || (32'(item_ff.pos_y) >= DIM_Y);
   assign item_addr = ADDR_W'((32'(z_sum) * DIM_Y + 32'(item_ff.pos_y)) * DIM_X
                              + 32'(item_ff.pos_x));

   // An average count of zero behaves as one.
   assign avg_n   = (avg_count_ff == '0) ? COST_W'(1) : avg_count_ff;
   assign avg_nm1 = avg_n - 1'b1;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: sweep, accept, read, merge, optional divide, write back.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      item_in       = item_ff;
      rej_in        = rej_ff;
      new_best_in   = new_best_ff;
      new_second_in = new_second_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      req_ready     = 1'b0;
      wr            = '0;
      rd            = '0;
      div_req       = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr.en      = 1'b1;
            wr.addr    = clr_cnt_ff;
            wr.best    = COST_MAX;
            wr.second  = COST_MAX;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(VOXELS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rej_in = item_rej;
            if (item_rej) begin
               new_best_in   = '0;
               new_second_in = '0;
               state_in      = ST_WRITE;
            end else begin
               rd.en    = 1'b1;
               rd.addr  = item_addr;
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            new_best_in   = rd_best;
            new_second_in = rd_second;
            state_in      = ST_WRITE;
            case (merge_mode_ff)
               MODE_COPY: begin
                  new_best_in = item_ff.cost;
               end
               MODE_MIN: begin
                  if (item_ff.cost < rd_best) begin
                     new_best_in = item_ff.cost;
                  end
               end
               MODE_BEST2: begin
                  if (item_ff.cost < rd_best) begin
                     new_second_in = rd_best;
                     new_best_in   = item_ff.cost;
                  end else if (item_ff.cost < rd_second) begin
                     new_second_in = item_ff.cost;
                  end
               end
               default: begin
                  sum_in   = SUM_W'(rd_best) * SUM_W'(avg_nm1) + SUM_W'(item_ff.cost);
                  state_in = ST_DIVGO;
               end
            endcase
         end
         ST_DIVGO: begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_ff;
            div_req.divisor  = avg_n;
            state_in         = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               new_best_in = div_quot;
               state_in    = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               wr.en                   = !rej_ff;
               wr.addr                 = item_addr;
               wr.best                 = new_best_ff;
               wr.second               = new_second_ff;
               rsp_valid_in            = 1'b1;
               rsp_data_in.best_cost   = new_best_ff;
               rsp_data_in.second_cost = new_second_ff;
               rsp_data_in.rejected    = rej_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      rej_ff        <= rej_in;
      new_best_ff   <= new_best_in;
      new_second_ff <= new_second_in;
      sum_ff        <= sum_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cvm_store u_store (
      .clock     (clock),
      .wr        (wr),
      .rd        (rd),
      .rd_best   (rd_best),
      .rd_second (rd_second)
   );

   cvm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

endmodule

// ===== tb/cost_volume_merge_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cost_volume_merge_tb: self-checking testbench for the cost volume merge unit
// Streams voxel transactions through the req channel and writes the control
// registers between phases. A local mirror of the best and second-best stores
// predicts every result, which is checked field by field on the rsp channel.
// Traffic runs under three backpressure profiles.
// ----------------------------------------------------------------------------
module cost_volume_merge_tb;
   import cvm_pkg::*;

   // The limit covers the post-reset sweep of the whole volume plus all the
   // traffic, even with both sides stalling, and leaves ample margin.
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int DRAIN_PAUSE  = 20;
   localparam int FINAL_PAUSE  = 40;
   localparam int MAX_IDLE_RUN = 30;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_data_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_data_type          rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Mirror of the block's registers and voxel stores. Voxels never written
   // are absent from the maps and read back as the cleared value.
   logic [MODE_W-1:0]  cfg_mode;
   logic [COST_W-1:0]  cfg_avg_count;
   logic [LZ_W-1:0]    cfg_z_base;
   logic [SLICE_W-1:0] cfg_slice_count;
   logic [COST_W-1:0]  best_mirror [int unsigned];
   logic [COST_W-1:0]  second_mirror [int unsigned];

   rsp_data_type merged_costs_due[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct;
   int           recv_idle_pct;

   cost_volume_merge dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // 20 ns clock.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d results outstanding",
                  cycle_count, merged_costs_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver backpressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic report_mismatch(input string what);
      begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
         error_count++;
      end
   endtask

   // Merge one voxel transaction into the mirror and return its result.
   function automatic rsp_data_type merge_voxel(input req_data_type item);
      rsp_data_type      res;
      int unsigned       slice;
      int unsigned       addr;
      int unsigned       n;
      int unsigned       sum;
      logic [COST_W-1:0] best_val;
      logic [COST_W-1:0] second_val;
      res   = '0;
      slice = cfg_z_base + item.local_z;
      if (item.local_z >= cfg_slice_count || slice >= DIM_Z ||
          item.pos_x >= DIM_X || item.pos_y >= DIM_Y) begin
         res.rejected = 1'b1;
         return res;
      end
      addr       = (slice * DIM_Y + item.pos_y) * DIM_X + item.pos_x;
      best_val   = best_mirror.exists(addr) ? best_mirror[addr] : COST_MAX;
      second_val = second_mirror.exists(addr) ? second_mirror[addr] : COST_MAX;
      case (cfg_mode)
         MODE_COPY: begin
            best_val = item.cost;
         end
         MODE_MIN: begin
            if (item.cost < best_val) best_val = item.cost;
         end
         MODE_BEST2: begin
            if (item.cost < best_val) begin
               second_val = best_val;
               best_val   = item.cost;
            end else if (item.cost < second_val) begin
               second_val = item.cost;
            end
         end
         default: begin
            // A zero count behaves as one, which makes the average a copy.
            n   = (cfg_avg_count == 0) ? 1 : cfg_avg_count;
            sum = (best_val * (n - 1) + item.cost) / n;
            best_val = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
         end
      endcase
      best_mirror[addr]   = best_val;
      second_mirror[addr] = second_val;
      res.best_cost   = best_val;
      res.second_cost = second_val;
      return res;
   endfunction

   // Length of an idle run, geometric in the given percentage, capped at MAX_IDLE_RUN.
   function automatic int idle_run(input int pct);
      int run;
      run = 0;
      while (run < MAX_IDLE_RUN && $urandom_range(99) < pct) run++;
      return run;
   endfunction

   function automatic req_data_type make_voxel(input int x, input int y,
                                               input int lz, input int cost);
      req_data_type item;
      item.pos_x   = x[POS_W-1:0];
      item.pos_y   = y[POS_W-1:0];
      item.local_z = lz[LZ_W-1:0];
      item.cost    = cost[COST_W-1:0];
      return item;
   endfunction

   // Send one voxel transaction and record its expected result on acceptance.
   // Valid stays high afterwards so back-to-back transactions need no gap.
   task automatic send_voxel(input req_data_type item);
      int gap;
      begin
         gap = idle_run(send_idle_pct);
         @(negedge clock);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= item;
         do @(posedge clock); while (!req_ready);
         merged_costs_due.push_back(merge_voxel(item));
      end
   endtask

   // Stop sending and wait until every result is back and the block is idle.
   task automatic drain_results;
      begin
         @(negedge clock);
         req_valid <= 1'b0;
         while (merged_costs_due.size() != 0) @(posedge clock);
         repeat (DRAIN_PAUSE) @(posedge clock);
      end
   endtask

   // Register writes happen only with the block idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      begin
         drain_results();
         @(negedge clock);
         csr_valid <= 1'b1;
         csr_index <= index;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
         case (index)
            CSR_MERGE_MODE:  cfg_mode        = value[MODE_W-1:0];
            CSR_AVG_COUNT:   cfg_avg_count   = value[COST_W-1:0];
            CSR_Z_BASE:      cfg_z_base      = value[LZ_W-1:0];
            CSR_SLICE_COUNT: cfg_slice_count = value[SLICE_W-1:0];
            default: ;
         endcase
         @(negedge clock);
         csr_valid <= 1'b0;
      end
   endtask

   // Compare each result transaction with the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (merged_costs_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", rsp_data));
         end else begin
            want = merged_costs_due.pop_front();
            if (rsp_data.best_cost !== want.best_cost)
               report_mismatch($sformatf("best_cost %0d, expected %0d",
                                         rsp_data.best_cost, want.best_cost));
            if (rsp_data.second_cost !== want.second_cost)
               report_mismatch($sformatf("second_cost %0d, expected %0d",
                                         rsp_data.second_cost, want.second_cost));
            if (rsp_data.rejected !== want.rejected)
               report_mismatch($sformatf("rejected %0b, expected %0b",
                                         rsp_data.rejected, want.rejected));
         end
      end
   end

   // Reset register values, with the corners of the volume in minimum mode.
   task automatic test_reset_defaults;
      begin
         send_voxel(make_voxel(0, 0, 0, 255));
         send_voxel(make_voxel(127, 127, 63, 0));
         send_voxel(make_voxel(127, 127, 63, 200));
         send_voxel(make_voxel(5, 6, 7, 100));
      end
   endtask

   // Copy, best-two and average modes on one voxel, then the average count extremes and minimum mode on another.
   task automatic test_merge_modes;
      begin
         write_csr(CSR_MERGE_MODE, {6'd0, MODE_COPY});
         send_voxel(make_voxel(5, 6, 7, 200));
         // Upper data bits of the mode register are ignored.
         write_csr(CSR_MERGE_MODE, {6'b111111, MODE_BEST2});
         send_voxel(make_voxel(5, 6, 7, 50));
         send_voxel(make_voxel(5, 6, 7, 120));
         send_voxel(make_voxel(5, 6, 7, 255));
         send_voxel(make_voxel(5, 6, 7, 50));
         write_csr(CSR_MERGE_MODE, {6'd0, MODE_AVG});
         write_csr(CSR_AVG_COUNT, 8'd3);
         send_voxel(make_voxel(5, 6, 7, 0));
         write_csr(CSR_AVG_COUNT, 8'd255);
         send_voxel(make_voxel(1, 1, 1, 255));
         // A zero count acts as a count of one.
         write_csr(CSR_AVG_COUNT, 8'd0);
         send_voxel(make_voxel(1, 1, 1, 7));
         write_csr(CSR_MERGE_MODE, {6'd0, MODE_MIN});
         send_voxel(make_voxel(1, 1, 1, 9));
      end
   endtask

   // Slice window edges: top of the volume, empty window, oversized window.
   task automatic test_slice_window;
      begin
         write_csr(CSR_Z_BASE, 8'd63);
         send_voxel(make_voxel(2, 3, 0, 10));
         send_voxel(make_voxel(2, 3, 1, 10));
         write_csr(CSR_SLICE_COUNT, 8'd0);
         send_voxel(make_voxel(2, 3, 0, 10));
         write_csr(CSR_Z_BASE, 8'd0);
         // Only the low seven bits of the slice count are kept.
         write_csr(CSR_SLICE_COUNT, 8'hFF);
         send_voxel(make_voxel(9, 9, 63, 1));
         write_csr(CSR_SLICE_COUNT, 8'd1);
         send_voxel(make_voxel(9, 9, 1, 1));
         send_voxel(make_voxel(9, 9, 0, 1));
      end
   endtask

   // Random register settings, each followed by traffic that mostly hits a
   // few hot voxels so the merges build on earlier results.
   task automatic test_random_merges(input int segments, input int per_segment);
      int hot_x[4];
      int hot_y[4];
      int hot_z[4];
      int window;
      int pick;
      int k;
      int sel;
      int mode_sel;
      int avg_val;
      int base_val;
      int count_val;
      begin
         for (int s = 0; s < segments; s++) begin
            mode_sel = $urandom_range(3);
            sel = $urandom_range(9);
            avg_val = (sel == 0) ? 0 : (sel == 1) ? 255 : $urandom_range(1, 8);
            sel = $urandom_range(9);
            base_val = (sel == 0) ? 0 : (sel == 1) ? 63 : $urandom_range(0, 40);
            sel = $urandom_range(19);
            count_val = (sel == 0) ? 0 : (sel == 1) ? 255 :
                        (sel == 2) ? 1 : $urandom_range(8, 64);
            write_csr(CSR_MERGE_MODE, {6'($urandom_range(63)), mode_sel[MODE_W-1:0]});
            write_csr(CSR_AVG_COUNT, avg_val[CSR_DATA_W-1:0]);
            write_csr(CSR_Z_BASE, base_val[CSR_DATA_W-1:0]);
            write_csr(CSR_SLICE_COUNT, count_val[CSR_DATA_W-1:0]);

            // Local slices that land inside both the window and the volume, when the window is not empty.
            window = (cfg_slice_count < DIM_Z - cfg_z_base) ?
                     cfg_slice_count : DIM_Z - cfg_z_base;
            for (k = 0; k < 4; k++) begin
               hot_x[k] = $urandom_range(127);
               hot_y[k] = $urandom_range(127);
               hot_z[k] = (window > 0) ? $urandom_range(window - 1) : $urandom_range(63);
            end

            for (int i = 0; i < per_segment; i++) begin
               pick = $urandom_range(99);
               k = $urandom_range(3);
               if (pick < 70)
                  send_voxel(make_voxel(hot_x[k], hot_y[k], hot_z[k], $urandom_range(255)));
               else if (pick < 85 && window > 0)
                  send_voxel(make_voxel($urandom_range(127), $urandom_range(127),
                                        $urandom_range(window - 1), $urandom_range(255)));
               else
                  send_voxel(make_voxel($urandom_range(127), $urandom_range(127),
                                        $urandom_range(63), $urandom_range(255)));
            end
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_MERGE_MODE;
      csr_data        = '0;
      cfg_mode        = MODE_MIN;
      cfg_avg_count   = 8'd1;
      cfg_z_base      = '0;
      cfg_slice_count = 7'd64;
      send_idle_pct   = 22;
      recv_idle_pct   = 57;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_merge_modes();
      test_slice_window();
      test_random_merges(4, 50);

      send_idle_pct = 57;
      recv_idle_pct = 22;
      test_random_merges(4, 50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_merges(4, 50);

      drain_results();
      repeat (FINAL_PAUSE) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
